// File: rtl/aptc_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the altitude PID thrust command block.
package aptc_pkg;

    localparam int CFG_W   = 32;
    localparam int ADDR_W  = 5;
    localparam int CHUNK_W = 16;

    localparam logic [30:0] GRAVITY_RESET = 31'd642908;
    localparam logic [30:0] CEILING_RESET = 31'h7FFF_FFFF;
    localparam logic [30:0] TICK_RESET    = 31'd655;

    typedef enum logic [2:0] {
        REG_GAIN_INTEGRAL  = 3'd0,
        REG_GAIN_POSITION  = 3'd1,
        REG_GAIN_VELOCITY  = 3'd2,
        REG_GRAVITY_ACCEL  = 3'd3,
        REG_THRUST_FLOOR   = 3'd4,
        REG_THRUST_CEILING = 3'd5,
        REG_TICK_PERIOD    = 3'd6
    } reg_idx_t;

    typedef enum logic [1:0] {
        CLAMP_NONE    = 2'd0,
        CLAMP_FLOOR   = 2'd1,
        CLAMP_CEILING = 2'd2
    } clamp_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_MUL,
        ST_FIN,
        ST_APPLY,
        ST_GRAV
    } state_t;

    typedef enum logic [2:0] {
        PR_TICK,
        PR_KI,
        PR_KP,
        PR_KV,
        PR_MASS
    } prod_t;

    typedef struct packed {
        logic signed [31:0] gain_integral;
        logic signed [31:0] gain_position;
        logic signed [31:0] gain_velocity;
        logic        [30:0] gravity_accel;
        logic        [30:0] thrust_floor;
        logic        [30:0] thrust_ceiling;
        logic        [30:0] tick_period;
    } cfg_t;

    typedef struct packed {
        logic  capture;
        logic  mul_load;
        logic  mul_step;
        logic  mul_fin;
        logic  apply;
        logic  grav;
        prod_t sel;
    } dp_cmd_t;

    typedef struct packed {
        logic mul_last;
        logic out_free;
    } dp_sts_t;

endpackage

// File: rtl/aptc_cfg_regs.sv
`timescale 1ns / 1ps
// APB configuration register file for gains, gravity, thrust limits and tick period.
module aptc_cfg_regs (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [aptc_pkg::ADDR_W-1:0]  paddr,
    input  logic [aptc_pkg::CFG_W-1:0]   pwdata,
    output logic [aptc_pkg::CFG_W-1:0]   prdata,
    output aptc_pkg::cfg_t               cfg
);
    import aptc_pkg::*;

    cfg_t     cfg_reg;
    cfg_t     cfg_next;
    reg_idx_t idx;
    logic     wr_en;

    assign idx   = reg_idx_t'(paddr[ADDR_W-1:2]);
    assign wr_en = psel && penable && pwrite;
    assign cfg   = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '{gain_integral:  '0,
                         gain_position:  '0,
                         gain_velocity:  '0,
                         gravity_accel:  GRAVITY_RESET,
                         thrust_floor:   '0,
                         thrust_ceiling: CEILING_RESET,
                         tick_period:    TICK_RESET};
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (idx)
                REG_GAIN_INTEGRAL:  cfg_next.gain_integral  = $signed(pwdata);
                REG_GAIN_POSITION:  cfg_next.gain_position  = $signed(pwdata);
                REG_GAIN_VELOCITY:  cfg_next.gain_velocity  = $signed(pwdata);
                REG_GRAVITY_ACCEL:  cfg_next.gravity_accel  = pwdata[30:0];
                REG_THRUST_FLOOR:   cfg_next.thrust_floor   = pwdata[30:0];
                REG_THRUST_CEILING: cfg_next.thrust_ceiling = pwdata[30:0];
                REG_TICK_PERIOD:    cfg_next.tick_period    = pwdata[30:0];
                default:            cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        case (idx)
            REG_GAIN_INTEGRAL:  prdata = cfg_reg.gain_integral;
            REG_GAIN_POSITION:  prdata = cfg_reg.gain_position;
            REG_GAIN_VELOCITY:  prdata = cfg_reg.gain_velocity;
            REG_GRAVITY_ACCEL:  prdata = {1'b0, cfg_reg.gravity_accel};
            REG_THRUST_FLOOR:   prdata = {1'b0, cfg_reg.thrust_floor};
            REG_THRUST_CEILING: prdata = {1'b0, cfg_reg.thrust_ceiling};
            REG_TICK_PERIOD:    prdata = {1'b0, cfg_reg.tick_period};
            default:            prdata = '0;
        endcase
    end

endmodule

// File: rtl/aptc_ctrl.sv
`timescale 1ns / 1ps
// Sequencer that steps the shared multiplier through the five products of one tick.
module aptc_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  aptc_pkg::dp_sts_t  sts,
    output aptc_pkg::dp_cmd_t  cmd
);
    import aptc_pkg::*;

    state_t state_reg;
    state_t state_next;
    prod_t  sel_reg;
    prod_t  sel_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            sel_reg   <= PR_TICK;
        end
        else
        begin
            state_reg <= state_next;
            sel_reg   <= sel_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        sel_next   = sel_reg;
        in_ready   = 1'b0;
        cmd        = '0;
        cmd.sel    = sel_reg;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    sel_next    = PR_TICK;
                    state_next  = ST_LOAD;
                end
            end
            ST_LOAD:
            begin
                cmd.mul_load = 1'b1;
                state_next   = ST_MUL;
            end
            ST_MUL:
            begin
                cmd.mul_step = 1'b1;
                if (sts.mul_last)
                begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN:
            begin
                cmd.mul_fin = 1'b1;
                state_next  = ST_APPLY;
            end
            ST_APPLY:
            begin
                case (sel_reg)
                    PR_TICK:
                    begin
                        cmd.apply  = 1'b1;
                        sel_next   = PR_KI;
                        state_next = ST_LOAD;
                    end
                    PR_KI:
                    begin
                        cmd.apply  = 1'b1;
                        sel_next   = PR_KP;
                        state_next = ST_LOAD;
                    end
                    PR_KP:
                    begin
                        cmd.apply  = 1'b1;
                        sel_next   = PR_KV;
                        state_next = ST_LOAD;
                    end
                    PR_KV:
                    begin
                        cmd.apply  = 1'b1;
                        state_next = ST_GRAV;
                    end
                    PR_MASS:
                    begin
                        // hold until the result register can take the beat
                        if (sts.out_free)
                        begin
                            cmd.apply  = 1'b1;
                            state_next = ST_IDLE;
                        end
                    end
                    default:
                    begin
                        state_next = ST_IDLE;
                    end
                endcase
            end
            ST_GRAV:
            begin
                cmd.grav   = 1'b1;
                sel_next   = PR_MASS;
                state_next = ST_LOAD;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// File: rtl/aptc_datapath.sv
`timescale 1ns / 1ps
// Datapath: error terms, integral, chunked multiplier, command sum, thrust clamp, result register.
module aptc_datapath #(
    parameter int FRAC_BITS  = 16,
    parameter int DATA_WIDTH = 32
) (
    input  logic               clk,
    input  logic               rst_n,
    input  aptc_pkg::dp_cmd_t  cmd,
    output aptc_pkg::dp_sts_t  sts,
    input  aptc_pkg::cfg_t     cfg,
    input  logic               restart,
    input  logic signed [31:0] altitude_target,
    input  logic signed [31:0] altitude_measured,
    input  logic signed [31:0] climb_rate_target,
    input  logic signed [31:0] climb_rate_measured,
    input  logic signed [31:0] accel_feedforward,
    input  logic [30:0]        vehicle_mass,
    input  logic               out_ready,
    output logic               out_valid,
    output logic [30:0]        thrust_command,
    output logic signed [31:0] altitude_error,
    output logic [1:0]         clamp_status
);
    import aptc_pkg::*;

    localparam int MW      = (DATA_WIDTH > 32) ? DATA_WIDTH : 32;
    localparam int SW      = MW + 1;
    localparam int EW      = MW + 3;
    localparam int NCH     = (MW + CHUNK_W - 1) / CHUNK_W;
    localparam int AW      = NCH * CHUNK_W;
    localparam int PRW     = AW + MW;
    localparam int PART_W  = CHUNK_W + MW;
    localparam int CW      = (NCH > 1) ? $clog2(NCH) : 1;

    localparam logic signed [DATA_WIDTH-1:0] D_MAX = {1'b0, {(DATA_WIDTH-1){1'b1}}};
    localparam logic signed [DATA_WIDTH-1:0] D_MIN = {1'b1, {(DATA_WIDTH-1){1'b0}}};

    function automatic logic signed [DATA_WIDTH-1:0] sat_dw(input logic signed [EW-1:0] v);
        logic [EW-DATA_WIDTH:0] top;
        top = v[EW-1:DATA_WIDTH-1];
        if ((&top) || !(|top))
            return v[DATA_WIDTH-1:0];
        else if (v[EW-1])
            return D_MIN;
        else
            return D_MAX;
    endfunction

    logic signed [DATA_WIDTH-1:0] alt_err_reg, alt_err_next;
    logic signed [DATA_WIDTH-1:0] rate_err_reg, rate_err_next;
    logic signed [DATA_WIDTH-1:0] integ_reg, integ_next;
    logic signed [31:0]           ff_reg, ff_next;
    logic [30:0]                  mass_reg, mass_next;
    logic signed [EW-1:0]         acc_reg, acc_next;
    logic [AW-1:0]                a_mag_reg, a_mag_next;
    logic [MW-1:0]                b_mag_reg, b_mag_next;
    logic                         neg_reg, neg_next;
    logic [CW-1:0]                cnt_reg, cnt_next;
    logic [PRW-1:0]               pacc_reg, pacc_next;
    logic signed [DATA_WIDTH-1:0] mres_reg, mres_next;
    logic                         out_valid_reg, out_valid_next;
    logic [30:0]                  thrust_reg, thrust_next;
    logic signed [31:0]           alt_out_reg, alt_out_next;
    clamp_t                       clamp_reg, clamp_next;

    logic signed [EW-1:0]         alt_diff;
    logic signed [EW-1:0]         rate_diff;
    logic signed [SW-1:0]         op_a;
    logic signed [SW-1:0]         op_b;
    logic signed [SW-1:0]         mag_a;
    logic signed [SW-1:0]         mag_b;
    logic [PART_W-1:0]            part;
    logic [PRW-1:0]               q;
    logic                         q_hi_nz;
    logic                         q_top;
    logic                         q_low_nz;
    logic signed [DATA_WIDTH-1:0] acc_sat;
    logic signed [SW-1:0]         thr_ext;
    logic signed [SW-1:0]         floor_ext;
    logic signed [SW-1:0]         ceil_ext;
    logic signed [SW-1:0]         alt_ext;
    logic                         out_load;

    assign alt_diff  = EW'(altitude_target) - EW'(altitude_measured);
    assign rate_diff = EW'(climb_rate_target) - EW'(climb_rate_measured);

    always_comb
    begin
        case (cmd.sel)
            PR_TICK:
            begin
                op_a = SW'(alt_err_reg);
                op_b = SW'($signed({1'b0, cfg.tick_period}));
            end
            PR_KI:
            begin
                op_a = SW'(cfg.gain_integral);
                op_b = SW'(integ_reg);
            end
            PR_KP:
            begin
                op_a = SW'(cfg.gain_position);
                op_b = SW'(alt_err_reg);
            end
            PR_KV:
            begin
                op_a = SW'(cfg.gain_velocity);
                op_b = SW'(rate_err_reg);
            end
            PR_MASS:
            begin
                op_a = SW'($signed({1'b0, mass_reg}));
                op_b = $signed(acc_reg[SW-1:0]);
            end
            default:
            begin
                op_a = '0;
                op_b = '0;
            end
        endcase
    end

    assign mag_a = op_a[SW-1] ? -op_a : op_a;
    assign mag_b = op_b[SW-1] ? -op_b : op_b;

    assign part = a_mag_reg[AW-1 -: CHUNK_W] * b_mag_reg;

    assign q        = pacc_reg >> FRAC_BITS;
    assign q_hi_nz  = |q[PRW-1:DATA_WIDTH];
    assign q_top    = q[DATA_WIDTH-1];
    assign q_low_nz = |q[DATA_WIDTH-2:0];

    assign acc_sat   = sat_dw(acc_reg);
    assign thr_ext   = SW'(mres_reg);
    assign floor_ext = SW'($signed({1'b0, cfg.thrust_floor}));
    assign ceil_ext  = SW'($signed({1'b0, cfg.thrust_ceiling}));
    assign alt_ext   = SW'(alt_err_reg);
    assign out_load  = cmd.apply && (cmd.sel == PR_MASS);

    always_comb
    begin
        alt_err_next  = alt_err_reg;
        rate_err_next = rate_err_reg;
        integ_next    = integ_reg;
        ff_next       = ff_reg;
        mass_next     = mass_reg;
        acc_next      = acc_reg;
        a_mag_next    = a_mag_reg;
        b_mag_next    = b_mag_reg;
        neg_next      = neg_reg;
        cnt_next      = cnt_reg;
        pacc_next     = pacc_reg;
        mres_next     = mres_reg;
        thrust_next   = thrust_reg;
        alt_out_next  = alt_out_reg;
        clamp_next    = clamp_reg;

        if (cmd.capture)
        begin
            alt_err_next  = sat_dw(alt_diff);
            rate_err_next = sat_dw(rate_diff);
            ff_next       = accel_feedforward;
            mass_next     = vehicle_mass;
            if (restart)
            begin
                integ_next = '0;
            end
        end

        if (cmd.mul_load)
        begin
            a_mag_next = AW'(mag_a[MW-1:0]);
            b_mag_next = mag_b[MW-1:0];
            neg_next   = op_a[SW-1] ^ op_b[SW-1];
            cnt_next   = '0;
            pacc_next  = '0;
        end

        if (cmd.mul_step)
        begin
            // top chunk first, shift the running sum up one chunk per step
            pacc_next  = (pacc_reg << CHUNK_W) + PRW'(part);
            a_mag_next = a_mag_reg << CHUNK_W;
            cnt_next   = cnt_reg + CW'(1);
        end

        if (cmd.mul_fin)
        begin
            if (neg_reg)
            begin
                if (q_hi_nz || (q_top && q_low_nz))
                    mres_next = D_MIN;
                else
                    mres_next = $signed(-q[DATA_WIDTH-1:0]);
            end
            else
            begin
                if (q_hi_nz || q_top)
                    mres_next = D_MAX;
                else
                    mres_next = $signed(q[DATA_WIDTH-1:0]);
            end
        end

        if (cmd.apply)
        begin
            case (cmd.sel)
                PR_TICK:
                begin
                    integ_next = sat_dw(EW'(integ_reg) + EW'(mres_reg));
                end
                PR_KI:
                begin
                    acc_next = EW'(ff_reg) + EW'(mres_reg);
                end
                PR_KP, PR_KV:
                begin
                    acc_next = acc_reg + EW'(mres_reg);
                end
                PR_MASS:
                begin
                    alt_out_next = alt_ext[31:0];
                    if (thr_ext < floor_ext)
                    begin
                        thrust_next = cfg.thrust_floor;
                        clamp_next  = CLAMP_FLOOR;
                    end
                    else if (thr_ext > ceil_ext)
                    begin
                        thrust_next = cfg.thrust_ceiling;
                        clamp_next  = CLAMP_CEILING;
                    end
                    else
                    begin
                        thrust_next = thr_ext[30:0];
                        clamp_next  = CLAMP_NONE;
                    end
                end
                default:
                begin
                    acc_next = acc_reg;
                end
            endcase
        end

        if (cmd.grav)
        begin
            acc_next = EW'(sat_dw(EW'(acc_sat) + EW'($signed({1'b0, cfg.gravity_accel}))));
        end
    end

    always_comb
    begin
        if (out_load)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            integ_reg     <= '0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            integ_reg     <= integ_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        alt_err_reg  <= alt_err_next;
        rate_err_reg <= rate_err_next;
        ff_reg       <= ff_next;
        mass_reg     <= mass_next;
        acc_reg      <= acc_next;
        a_mag_reg    <= a_mag_next;
        b_mag_reg    <= b_mag_next;
        neg_reg      <= neg_next;
        pacc_reg     <= pacc_next;
        mres_reg     <= mres_next;
        thrust_reg   <= thrust_next;
        alt_out_reg  <= alt_out_next;
        clamp_reg    <= clamp_next;
    end

    assign sts.mul_last = (cnt_reg == CW'(NCH - 1));
    assign sts.out_free = !out_valid_reg || out_ready;

    assign out_valid      = out_valid_reg;
    assign thrust_command = thrust_reg;
    assign altitude_error = alt_out_reg;
    assign clamp_status   = clamp_reg;

endmodule

// File: rtl/altitude_pid_thrust_command.sv
`timescale 1ns / 1ps
// Altitude PID thrust command: top level with APB register port and item channels.
// Each input beat runs five multiplies in turn on one shared 16-bit by word-wide multiplier,
// N partial products each, N = ceil(max(DATA_WIDTH,32)/16); a new input beat is taken only
// once the previous tick has finished all five.
// A held result does not block the next input beat; the next result waits for it to drain.
// Reset: gains, floor and integral clear, gravity, ceiling and tick period to defaults, no beat held.
module altitude_pid_thrust_command #(
    parameter int FRAC_BITS  = 16,
    parameter int DATA_WIDTH = 32
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [aptc_pkg::ADDR_W-1:0]  paddr,
    input  logic [aptc_pkg::CFG_W-1:0]   pwdata,
    output logic [aptc_pkg::CFG_W-1:0]   prdata,
    output logic                         pready,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic                         restart,
    input  logic signed [31:0]           altitude_target,
    input  logic signed [31:0]           altitude_measured,
    input  logic signed [31:0]           climb_rate_target,
    input  logic signed [31:0]           climb_rate_measured,
    input  logic signed [31:0]           accel_feedforward,
    input  logic [30:0]                  vehicle_mass,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [30:0]                  thrust_command,
    output logic signed [31:0]           altitude_error,
    output logic [1:0]                   clamp_status
);
    import aptc_pkg::*;

    cfg_t    cfg;
    dp_cmd_t cmd;
    dp_sts_t sts;

    assign pready = 1'b1;

    aptc_cfg_regs u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .cfg     (cfg)
    );

    aptc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    aptc_datapath #(
        .FRAC_BITS  (FRAC_BITS),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_dp (
        .clk                 (clk),
        .rst_n               (rst_n),
        .cmd                 (cmd),
        .sts                 (sts),
        .cfg                 (cfg),
        .restart             (restart),
        .altitude_target     (altitude_target),
        .altitude_measured   (altitude_measured),
        .climb_rate_target   (climb_rate_target),
        .climb_rate_measured (climb_rate_measured),
        .accel_feedforward   (accel_feedforward),
        .vehicle_mass        (vehicle_mass),
        .out_ready           (out_ready),
        .out_valid           (out_valid),
        .thrust_command      (thrust_command),
        .altitude_error      (altitude_error),
        .clamp_status        (clamp_status)
    );

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("input taken while a tick is in progress");

    a_fin_after_last_step: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.mul_fin |-> $past(cmd.mul_step && sts.mul_last))
        else $error("product finished before its last partial product");

    a_result_from_mass: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(cmd.apply && (cmd.sel == PR_MASS)))
        else $error("result beat raised without a thrust clamp step");

endmodule

// File: bench/tb_altitude_pid_thrust_command.sv
`timescale 1ns / 1ps
// Self-checking bench for the altitude PID thrust command: APB setup, random ticks, scoreboard.

typedef struct {
    logic              restart;
    logic signed [31:0] altitude_target;
    logic signed [31:0] altitude_measured;
    logic signed [31:0] climb_rate_target;
    logic signed [31:0] climb_rate_measured;
    logic signed [31:0] accel_feedforward;
    logic        [30:0] vehicle_mass;
} thrust_tick_t;

typedef struct {
    logic        [30:0] thrust;
    logic signed [31:0] alt_err;
    aptc_pkg::clamp_t   status;
} thrust_cmd_t;

class thrust_ledger;
    logic signed [31:0] ki;
    logic signed [31:0] kp;
    logic signed [31:0] kv;
    logic        [30:0] gravity;
    logic        [30:0] floor_lim;
    logic        [30:0] ceil_lim;
    logic        [30:0] period;
    longint             integral;
    thrust_cmd_t        pending[$];
    int                 failures;

    function new();
        ki        = '0;
        kp        = '0;
        kv        = '0;
        gravity   = aptc_pkg::GRAVITY_RESET;
        floor_lim = '0;
        ceil_lim  = aptc_pkg::CEILING_RESET;
        period    = aptc_pkg::TICK_RESET;
        integral  = 0;
        failures  = 0;
    endfunction

    function void set_register(int idx, logic [31:0] value);
        case (idx)
            aptc_pkg::REG_GAIN_INTEGRAL:  ki = value;
            aptc_pkg::REG_GAIN_POSITION:  kp = value;
            aptc_pkg::REG_GAIN_VELOCITY:  kv = value;
            aptc_pkg::REG_GRAVITY_ACCEL:  gravity = value[30:0];
            aptc_pkg::REG_THRUST_FLOOR:   floor_lim = value[30:0];
            aptc_pkg::REG_THRUST_CEILING: ceil_lim = value[30:0];
            aptc_pkg::REG_TICK_PERIOD:    period = value[30:0];
            default: ;
        endcase
    endfunction

    function longint clip(longint v);
        if (v > 64'sd2147483647)
            return 64'sd2147483647;
        if (v < -64'sd2147483648)
            return -64'sd2147483648;
        return v;
    endfunction

    // truncate toward zero, then saturate
    function longint qmul(longint a, longint b);
        longint p;
        longint m;
        p = a * b;
        m = (p < 0) ? -p : p;
        m = m >> 16;
        return clip((p < 0) ? -m : m);
    endfunction

    function void note_tick(thrust_tick_t t);
        longint      alt;
        longint      rate;
        longint      acc;
        longint      thr;
        thrust_cmd_t e;
        if (t.restart)
            integral = 0;
        alt = clip(longint'(t.altitude_target) - longint'(t.altitude_measured));
        rate = clip(longint'(t.climb_rate_target) - longint'(t.climb_rate_measured));
        integral = clip(integral + qmul(alt, longint'(period)));
        acc = clip(qmul(longint'(ki), integral) + qmul(longint'(kp), alt)
                   + qmul(longint'(kv), rate) + longint'(t.accel_feedforward));
        acc = clip(acc + longint'(gravity));
        thr = qmul(longint'(t.vehicle_mass), acc);
        e.status = aptc_pkg::CLAMP_NONE;
        if (thr < longint'(floor_lim))
        begin
            thr = longint'(floor_lim);
            e.status = aptc_pkg::CLAMP_FLOOR;
        end
        else if (thr > longint'(ceil_lim))
        begin
            thr = longint'(ceil_lim);
            e.status = aptc_pkg::CLAMP_CEILING;
        end
        e.thrust  = thr[30:0];
        e.alt_err = alt[31:0];
        pending.push_back(e);
    endfunction

    function void check_command(thrust_cmd_t got);
        thrust_cmd_t e;
        if (pending.size() == 0)
        begin
            $display("%0t unexpected result: thrust %0d altitude_error %0d clamp %0d",
                     $time, got.thrust, got.alt_err, got.status);
            failures++;
            return;
        end
        e = pending.pop_front();
        if (got.thrust !== e.thrust)
        begin
            $display("%0t thrust_command expected %0d actual %0d", $time, e.thrust, got.thrust);
            failures++;
        end
        if (got.alt_err !== e.alt_err)
        begin
            $display("%0t altitude_error expected %0d actual %0d", $time, e.alt_err, got.alt_err);
            failures++;
        end
        if (got.status !== e.status)
        begin
            $display("%0t clamp_status expected %0d actual %0d", $time, e.status, got.status);
            failures++;
        end
    endfunction
endclass

module tb_altitude_pid_thrust_command;
    import aptc_pkg::*;

    localparam int ONE          = 65536;
    localparam int REG_UNMAPPED = 7;
    localparam int QUIET_LIMIT  = 4000;
    localparam int SEGMENT_LEN  = 272;

    typedef enum {
        PROFILE_FLIGHT,
        PROFILE_HIGH,
        PROFILE_LOW,
        PROFILE_NOISE
    } profile_t;

    logic                clk = 1'b0;
    logic                rst_n;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [ADDR_W-1:0]   paddr;
    logic [CFG_W-1:0]    pwdata;
    logic [CFG_W-1:0]    prdata;
    logic                pready;
    logic                in_valid;
    logic                in_ready;
    logic                restart;
    logic signed [31:0]  altitude_target;
    logic signed [31:0]  altitude_measured;
    logic signed [31:0]  climb_rate_target;
    logic signed [31:0]  climb_rate_measured;
    logic signed [31:0]  accel_feedforward;
    logic [30:0]         vehicle_mass;
    logic                out_valid;
    logic                out_ready;
    logic [30:0]         thrust_command;
    logic signed [31:0]  altitude_error;
    logic [1:0]          clamp_status;

    int send_gap_pct = 0;
    int recv_stall_pct = 0;
    int quiet = 0;

    thrust_ledger ledger = new;

    altitude_pid_thrust_command dut (
        .clk                 (clk),
        .rst_n               (rst_n),
        .psel                (psel),
        .penable             (penable),
        .pwrite              (pwrite),
        .paddr               (paddr),
        .pwdata              (pwdata),
        .prdata              (prdata),
        .pready              (pready),
        .in_valid            (in_valid),
        .in_ready            (in_ready),
        .restart             (restart),
        .altitude_target     (altitude_target),
        .altitude_measured   (altitude_measured),
        .climb_rate_target   (climb_rate_target),
        .climb_rate_measured (climb_rate_measured),
        .accel_feedforward   (accel_feedforward),
        .vehicle_mass        (vehicle_mass),
        .out_valid           (out_valid),
        .out_ready           (out_ready),
        .thrust_command      (thrust_command),
        .altitude_error      (altitude_error),
        .clamp_status        (clamp_status)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    function automatic int spread(int unsigned span);
        return int'($urandom_range(0, 2 * span)) - int'(span);
    endfunction

    function automatic thrust_tick_t make_tick(logic rs, logic [31:0] tgt, logic [31:0] meas,
                                               logic [31:0] crt, logic [31:0] crm,
                                               logic [31:0] ff, logic [31:0] mass);
        thrust_tick_t t;
        t.restart             = rs;
        t.altitude_target     = tgt;
        t.altitude_measured   = meas;
        t.climb_rate_target   = crt;
        t.climb_rate_measured = crm;
        t.accel_feedforward   = ff;
        t.vehicle_mass        = mass[30:0];
        return t;
    endfunction

    task automatic apb_write(input int idx, input logic [31:0] value);
        logic [ADDR_W-1:0] addr;
        addr = ADDR_W'(4 * idx);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        ledger.set_register(idx, value);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
    endtask

    task automatic send_tick(input thrust_tick_t t);
        while ($urandom_range(99) < send_gap_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid            <= 1'b1;
        restart             <= t.restart;
        altitude_target     <= t.altitude_target;
        altitude_measured   <= t.altitude_measured;
        climb_rate_target   <= t.climb_rate_target;
        climb_rate_measured <= t.climb_rate_measured;
        accel_feedforward   <= t.accel_feedforward;
        vehicle_mass        <= t.vehicle_mass;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        ledger.note_tick(t);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (ledger.pending.size() != 0)
            @(posedge clk);
    endtask

    task automatic program_settings(input profile_t profile);
        logic [31:0] v [7];
        case (profile)
            PROFILE_FLIGHT:
            begin
                v[0] = $urandom_range(0, ONE);
                v[1] = $urandom_range(0, 8 * ONE);
                v[2] = $urandom_range(0, 8 * ONE);
                v[3] = $urandom_range(9 * ONE, 11 * ONE);
                v[4] = $urandom_range(0, 2000 * ONE);
                v[5] = $urandom_range(5000 * ONE, 32767 * ONE);
                v[6] = $urandom_range(1, ONE / 10);
            end
            PROFILE_HIGH:
                v = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0,
                      32'h0, 32'h7FFF_FFFF, 32'h7FFF_FFFF};
            PROFILE_LOW:
                v = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                      32'h7FFF_FFFF, 32'h0, 32'h0};
            default:
                foreach (v[i])
                    v[i] = $urandom();
        endcase
        apb_write(REG_GAIN_INTEGRAL, v[0]);
        apb_write(REG_GAIN_POSITION, v[1]);
        apb_write(REG_GAIN_VELOCITY, v[2]);
        apb_write(REG_GRAVITY_ACCEL, v[3]);
        apb_write(REG_THRUST_FLOOR, v[4]);
        apb_write(REG_THRUST_CEILING, v[5]);
        apb_write(REG_TICK_PERIOD, v[6]);
    endtask

    task automatic run_flights(input int count);
        int           sent;
        int           len;
        int           tgt;
        int           meas;
        int           crt;
        logic [30:0]  mass;
        thrust_tick_t t;
        sent = 0;
        while (sent < count)
        begin
            if ($urandom_range(99) < 20)
            begin
                t.restart             = 1'($urandom_range(1));
                t.altitude_target     = $urandom();
                t.altitude_measured   = $urandom();
                t.climb_rate_target   = $urandom();
                t.climb_rate_measured = $urandom();
                t.accel_feedforward   = $urandom();
                t.vehicle_mass        = 31'($urandom_range(0, 32'h7FFF_FFFF));
                send_tick(t);
                sent++;
            end
            else
            begin
                len  = $urandom_range(5, 30);
                tgt  = spread(500 * ONE);
                meas = tgt + spread(50 * ONE);
                mass = 31'($urandom_range(ONE, 400 * ONE));
                for (int k = 0; k < len; k++)
                begin
                    crt  = spread(10 * ONE);
                    meas = meas + (tgt - meas) / 8 + spread(ONE);
                    t.restart             = (k == 0) || ($urandom_range(99) < 3);
                    t.altitude_target     = tgt;
                    t.altitude_measured   = meas;
                    t.climb_rate_target   = crt;
                    t.climb_rate_measured = crt + spread(3 * ONE);
                    t.accel_feedforward   = spread(5 * ONE);
                    t.vehicle_mass        = mass;
                    send_tick(t);
                    sent++;
                end
            end
        end
    endtask

    initial
    begin
        out_ready <= 1'b0;
        forever
        begin
            thrust_cmd_t got;
            @(posedge clk);
            if (rst_n && out_valid && out_ready)
            begin
                got.thrust  = thrust_command;
                got.alt_err = altitude_error;
                got.status  = clamp_t'(clamp_status);
                ledger.check_command(got);
            end
            out_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    initial
    begin
        while (quiet < QUIET_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready) || (psel && penable))
                quiet = 0;
            else
                quiet++;
        end
        $display("tb_altitude_pid_thrust_command failed");
        $finish;
    end

    initial
    begin
        profile_t plan [6];
        plan = '{PROFILE_FLIGHT, PROFILE_HIGH, PROFILE_FLIGHT,
                 PROFILE_LOW, PROFILE_FLIGHT, PROFILE_NOISE};
        rst_n               <= 1'b0;
        psel                <= 1'b0;
        penable             <= 1'b0;
        pwrite              <= 1'b0;
        paddr               <= '0;
        pwdata              <= '0;
        in_valid            <= 1'b0;
        restart             <= 1'b0;
        altitude_target     <= '0;
        altitude_measured   <= '0;
        climb_rate_target   <= '0;
        climb_rate_measured <= '0;
        accel_feedforward   <= '0;
        vehicle_mass        <= '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_tick(make_tick(1'b1, 0, 0, 0, 0, 0, 0));
        send_tick(make_tick(1'b0, 0, 0, 0, 0, 0, ONE));
        drain();
        apb_write(REG_GAIN_INTEGRAL, ONE / 4);
        apb_write(REG_GAIN_POSITION, 2 * ONE);
        apb_write(REG_GAIN_VELOCITY, 3 * ONE / 2);
        apb_write(REG_GRAVITY_ACCEL, {1'b0, GRAVITY_RESET});
        apb_write(REG_THRUST_FLOOR, 100 * ONE);
        apb_write(REG_THRUST_CEILING, 20000 * ONE);
        apb_write(REG_TICK_PERIOD, {1'b0, TICK_RESET});
        apb_write(REG_UNMAPPED, 32'h1234_5678);
        send_tick(make_tick(1'b0, 32'h7FFF_FFFF, 32'h8000_0000, 0, 0, 0, 10 * ONE));
        send_tick(make_tick(1'b0, 32'h8000_0000, 32'h7FFF_FFFF, 0, 0, 0, 10 * ONE));
        send_tick(make_tick(1'b1, 100 * ONE, 95 * ONE, 2 * ONE, ONE, 0, 10 * ONE));
        send_tick(make_tick(1'b0, 0, 0, 32'h7FFF_FFFF, 32'h8000_0000, 0, 10 * ONE));
        send_tick(make_tick(1'b0, 0, 0, 32'h8000_0000, 32'h7FFF_FFFF, 0, 10 * ONE));
        send_tick(make_tick(1'b1, 0, 0, 0, 0, 32'h7FFF_FFFF, 10 * ONE));
        send_tick(make_tick(1'b1, 0, 0, 0, 0, 32'h8000_0000, 10 * ONE));
        send_tick(make_tick(1'b1, ONE, 0, 0, 0, 0, 32'h7FFF_FFFF));
        send_tick(make_tick(1'b1, ONE, 0, 0, 0, 0, 0));
        send_tick(make_tick(1'b0, 50 * ONE, 49 * ONE, ONE, 0, ONE / 2, 200 * ONE));
        drain();
        apb_write(REG_TICK_PERIOD, 32'h7FFF_FFFF);
        send_tick(make_tick(1'b1, 32'h7FFF_FFFF, 32'h8000_0000, 0, 0, 0, 10 * ONE));
        send_tick(make_tick(1'b0, 32'h7FFF_FFFF, 32'h8000_0000, 0, 0, 0, 10 * ONE));
        send_tick(make_tick(1'b0, 32'h8000_0000, 32'h7FFF_FFFF, 0, 0, 0, 10 * ONE));
        send_tick(make_tick(1'b1, 32'h8000_0000, 32'h7FFF_FFFF, 0, 0, 0, 10 * ONE));
        drain();
        apb_write(REG_THRUST_FLOOR, 20000 * ONE);
        apb_write(REG_THRUST_CEILING, 100 * ONE);
        apb_write(REG_TICK_PERIOD, {1'b0, TICK_RESET});
        send_tick(make_tick(1'b1, 0, 0, 0, 0, 0, ONE));
        send_tick(make_tick(1'b1, 0, 0, 0, 0, 0, 32'h7FFF_FFFF));
        send_tick(make_tick(1'b1, 0, 0, 0, 0, 32'h8000_0000, 10 * ONE));
        send_tick(make_tick(1'b1, 0, 0, 0, 0, 0, 2500 * ONE));
        drain();

        for (int seg = 0; seg < 6; seg++)
        begin
            case (seg / 2)
                0:
                begin
                    send_gap_pct   = 25;
                    recv_stall_pct = 48;
                end
                1:
                begin
                    send_gap_pct   = 48;
                    recv_stall_pct = 25;
                end
                default:
                begin
                    send_gap_pct   = 0;
                    recv_stall_pct = 0;
                end
            endcase
            program_settings(plan[seg]);
            run_flights(SEGMENT_LEN);
            drain();
        end

        repeat (40) @(posedge clk);
        if (ledger.failures == 0 && ledger.pending.size() == 0)
            $display("tb_altitude_pid_thrust_command passed");
        else
            $display("tb_altitude_pid_thrust_command failed");
        $finish;
    end
endmodule
